// ===== hdl/mrfd_pkg.sv =====
package mrfd_pkg;

    // Frame layout
    localparam logic [4:0] HEAD_BYTES  = 5'd5;
    localparam logic [4:0] MAX_PAYLOAD = 5'd16;
    localparam logic [4:0] TAIL_BYTES  = 5'd2;
    // Scan always covers header plus the full payload window
    localparam logic [4:0] SCAN_MIN    = 5'd21;

    // Result status codes
    localparam logic [2:0] ST_DATA     = 3'd0;
    localparam logic [2:0] ST_OK       = 3'd1;
    localparam logic [2:0] ST_BAD_ADDR = 3'd2;
    localparam logic [2:0] ST_BAD_CMD  = 3'd3;
    localparam logic [2:0] ST_BAD_CRC  = 3'd4;

    // Decode modes
    localparam logic [2:0] MODE_RAW   = 3'd0;
    localparam logic [2:0] MODE_CNT   = 3'd1;
    localparam logic [2:0] MODE_DATE  = 3'd2;
    localparam logic [2:0] MODE_SCHED = 3'd3;
    localparam logic [2:0] MODE_VAP   = 3'd4;
    localparam logic [2:0] MODE_WORK  = 3'd5;

    // Configuration register indexes
    localparam logic [2:0] REG_ADDR  = 3'd0;
    localparam logic [2:0] REG_CMD   = 3'd1;
    localparam logic [2:0] REG_CHK   = 3'd2;
    localparam logic [2:0] REG_PLEN  = 3'd3;
    localparam logic [2:0] REG_MODE  = 3'd4;
    localparam logic [2:0] REG_SEED  = 3'd5;

    typedef struct packed {
        logic [4:0] flen;
        logic [4:0] plen;
        logic [2:0] mode;
    } job_t;

    typedef struct packed {
        logic [31:0] expected_addr;
        logic [7:0]  expected_cmd;
        logic        check_address;
        logic [15:0] crc_seed;
    } cfg_t;

    typedef struct packed {
        logic       en;
        logic [4:0] addr;
        logic [7:0] data;
    } wr_t;

    typedef struct packed {
        logic [3:0] start;
        logic [2:0] len;
    } run_t;

    typedef struct packed {
        logic [2:0] word;
        logic [1:0] bsel;
    } sel_t;

    typedef struct packed {
        logic       found;
        logic [2:0] idx;
    } pick_t;

    // Two nibbles weighted as decimal digits
    function automatic logic [7:0] bcd2(logic [7:0] b);
        return ({4'h0, b[7:4]} * 8'd10) + {4'h0, b[3:0]};
    endfunction

    // One byte through the reflected 0xA001 CRC
    function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        return c;
    endfunction

    // Lowest set bit of an 8-bit mask
    function automatic pick_t low_bit(logic [7:0] v);
        pick_t p;
        p = '0;
        for (int i = 7; i >= 0; i--) begin
            if (v[i]) begin
                p.found = 1'b1;
                p.idx   = 3'(i);
            end
        end
        return p;
    endfunction

    // BCD run (payload start, digit pairs) per mode and run index
    function automatic run_t run_info(logic [2:0] mode, logic [2:0] run);
        run_t r;
        r = '{start: 4'd0, len: 3'd1};
        case (mode)
            MODE_CNT: r = '{start: {run[1:0], 2'b00}, len: 3'd4};
            MODE_VAP: begin
                case (run)
                    3'd0:    r = '{start: 4'd0, len: 3'd2};
                    3'd1:    r = '{start: 4'd2, len: 3'd2};
                    default: r = '{start: 4'd4, len: 3'd3};
                endcase
            end
            MODE_WORK: begin
                case (run)
                    3'd0:    r = '{start: 4'd0, len: 3'd3};
                    default: r = '{start: 4'd3, len: 3'd3};
                endcase
            end
            default: r = '{start: 4'd0, len: 3'd1};
        endcase
        return r;
    endfunction

    function automatic logic [2:0] run_count(logic [2:0] mode);
        case (mode)
            MODE_CNT:  return 3'd4;
            MODE_VAP:  return 3'd3;
            MODE_WORK: return 3'd2;
            default:   return 3'd1;
        endcase
    endfunction

    function automatic logic [4:0] word_count(logic [2:0] mode);
        case (mode)
            MODE_CNT:  return 5'd20;
            MODE_VAP:  return 5'd7;
            MODE_WORK: return 5'd6;
            default:   return 5'd1;
        endcase
    endfunction

    // Word and big-endian byte for output byte j of a word mode
    function automatic sel_t emit_sel(logic [2:0] mode, logic [4:0] j);
        sel_t s;
        s = '0;
        case (mode)
            MODE_CNT: begin
                s.word = 3'(j[4:2]);
                s.bsel = 2'd3 - j[1:0];
            end
            MODE_VAP: begin
                if (j < 5'd2) begin
                    s.word = 3'd0;
                    s.bsel = 2'(5'd1 - j);
                end else if (j < 5'd4) begin
                    s.word = 3'd1;
                    s.bsel = 2'(5'd3 - j);
                end else begin
                    s.word = 3'd2;
                    s.bsel = 2'(5'd6 - j);
                end
            end
            MODE_WORK: begin
                if (j < 5'd3) begin
                    s.word = 3'd0;
                    s.bsel = 2'(5'd2 - j);
                end else begin
                    s.word = 3'd1;
                    s.bsel = 2'(5'd5 - j);
                end
            end
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

// ===== hdl/mrfd_front.sv =====
module mrfd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          rx_byte,
    output mrfd_pkg::cfg_t      cfg,
    output mrfd_pkg::wr_t       wr,
    output mrfd_pkg::job_t      job,
    output logic                push,
    input  logic                done
);
    import mrfd_pkg::*;

    logic [31:0] expected_addr_reg;
    logic [7:0]  expected_cmd_reg;
    logic        check_address_reg;
    logic [4:0]  payload_length_reg;
    logic [2:0]  decode_mode_reg;
    logic [15:0] crc_seed_reg;
    logic [4:0]  byte_count_reg;
    logic [4:0]  byte_count_next;
    logic        pend_reg;
    logic        pend_next;

    logic [4:0]  plen;
    logic [4:0]  flen;
    logic [4:0]  cnt;
    logic        accept;
    logic        frame_end;

    // Frame length from the current payload length, clamped
    assign plen      = (payload_length_reg > MAX_PAYLOAD) ? MAX_PAYLOAD : payload_length_reg;
    assign flen      = plen + HEAD_BYTES + TAIL_BYTES;
    assign accept    = in_valid && !pend_reg;
    assign cnt       = byte_count_reg + 5'd1;
    assign frame_end = accept && (cnt >= flen);

    assign in_stall = pend_reg;
    assign push     = frame_end;
    assign job      = '{flen: flen, plen: plen, mode: decode_mode_reg};
    assign wr       = '{en: accept, addr: byte_count_reg, data: rx_byte};
    assign cfg      = '{expected_addr: expected_addr_reg, expected_cmd: expected_cmd_reg,
                        check_address: check_address_reg, crc_seed: crc_seed_reg};

    // Byte counter and frame-pending flag
    always_comb
    begin
        byte_count_next = byte_count_reg;
        pend_next       = pend_reg;
        if (accept)
        begin
            byte_count_next = frame_end ? 5'd0 : cnt;
        end
        if (frame_end)
        begin
            pend_next = 1'b1;
        end
        else if (done)
        begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            pend_reg       <= 1'b0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            pend_reg       <= pend_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_addr_reg  <= '0;
            expected_cmd_reg   <= '0;
            check_address_reg  <= 1'b1;
            payload_length_reg <= '0;
            decode_mode_reg    <= MODE_RAW;
            crc_seed_reg       <= 16'hFFFF;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ADDR: expected_addr_reg  <= cfg_data;
                REG_CMD:  expected_cmd_reg   <= cfg_data[7:0];
                REG_CHK:  check_address_reg  <= cfg_data[0];
                REG_PLEN: payload_length_reg <= cfg_data[4:0];
                REG_MODE: decode_mode_reg    <= cfg_data[2:0];
                REG_SEED: crc_seed_reg       <= cfg_data[15:0];
                default:  ;
            endcase
        end
    end

endmodule

// ===== hdl/mrfd_job_q.sv =====
module mrfd_job_q (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mrfd_pkg::job_t din,
    input  logic           pop,
    output mrfd_pkg::job_t head,
    output logic           empty,
    output logic           full
);
    import mrfd_pkg::*;

    job_t       slot_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;

    assign head  = slot_reg[rp_reg];
    assign empty = (cnt_reg == 2'd0);
    assign full  = (cnt_reg == 2'd2);

    // Two-entry job queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                slot_reg[wp_reg] <= din;
                wp_reg           <= !wp_reg;
            end
            if (pop && !empty)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push && !full) - 2'(pop && !empty);
        end
    end

endmodule

// ===== hdl/mrfd_back.sv =====
module mrfd_back #(
    parameter int FRAME_BYTES = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  mrfd_pkg::cfg_t cfg,
    input  mrfd_pkg::wr_t  wr,
    input  mrfd_pkg::job_t job,
    input  logic           q_empty,
    output logic           pop,
    output logic           done,
    output logic           busy,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [7:0]     out_byte,
    output logic [2:0]     status,
    output logic           last
);
    import mrfd_pkg::*;

    localparam int AW = $clog2(FRAME_BYTES);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_CHECK, S_RUN, S_EMIT} state_t;

    // Frame store
    logic [7:0] store_mem [FRAME_BYTES];
    logic [7:0] mem_q;

    state_t      state_reg, state_next;
    job_t        job_reg, job_next;
    logic [4:0]  issue_reg, issue_next;
    logic        dv_reg, dv_next;
    logic [4:0]  didx_reg, didx_next;
    logic [7:0]  hdr_reg [5];
    logic [7:0]  hdr_next [5];
    logic [7:0]  pay_reg [16];
    logic [7:0]  pay_next [16];
    logic [7:0]  keep_reg, keep_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] rxc_reg, rxc_next;
    logic [2:0]  run_reg, run_next;
    logic [2:0]  step_reg, step_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] sum_reg, sum_next;
    logic [31:0] w_reg [5];
    logic [31:0] w_next [5];
    logic [4:0]  j_reg, j_next;
    logic [2:0]  e_reg, e_next;
    logic [1:0]  sub_reg, sub_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic [2:0]  status_reg, status_next;
    logic        last_reg, last_next;

    logic [4:0]  scan_end;
    logic        out_free;
    logic [3:0]  pay_idx;
    logic [7:0]  pay_rd;
    run_t        ri;
    logic [31:0] acc_step;
    logic [7:0]  keep_act;
    pick_t       first_pick;
    pick_t       next_pick;
    logic [7:0]  above_mask;
    logic [31:0] addr_rx;
    sel_t        sel;
    logic [31:0] wv;
    logic [3:0]  pi;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            store_mem[AW'(wr.addr)] <= wr.data;
        end
        mem_q <= store_mem[AW'(issue_reg)];
    end

    assign scan_end = (job_reg.flen > SCAN_MIN) ? job_reg.flen : SCAN_MIN;
    assign out_free = !out_valid_reg || !out_stall;
    assign ri       = run_info(job_reg.mode, run_reg);
    assign addr_rx  = {hdr_reg[3], hdr_reg[2], hdr_reg[1], hdr_reg[0]};
    assign keep_act = keep_reg & 8'((9'd1 << job_reg.plen[4:1]) - 9'd1);
    assign first_pick = low_bit(keep_act);
    // Entries above the current one
    assign above_mask = ~((8'd2 << e_reg) - 8'd1);
    assign next_pick  = low_bit(keep_reg & above_mask);
    assign sel = emit_sel(job_reg.mode, j_reg);
    assign wv  = w_reg[sel.word];
    assign pi  = 4'(didx_reg - HEAD_BYTES);

    // One payload read point shared by the run and emit steps
    always_comb
    begin
        if (state_reg == S_RUN)
        begin
            pay_idx = ri.start + {1'b0, step_reg};
        end
        else if (job_reg.mode == MODE_SCHED)
        begin
            pay_idx = {e_reg, sub_reg == 2'd2};
        end
        else
        begin
            pay_idx = j_reg[3:0];
        end
    end
    assign pay_rd = pay_reg[pay_idx];

    // acc * 100 + digit pair
    assign acc_step = (acc_reg << 6) + (acc_reg << 5) + (acc_reg << 2)
                      + {24'h0, bcd2(pay_rd)};

    assign pop       = (state_reg == S_IDLE) && !q_empty;
    assign busy      = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign status    = status_reg;
    assign last      = last_reg;

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        issue_next     = issue_reg;
        dv_next        = 1'b0;
        didx_next      = didx_reg;
        hdr_next       = hdr_reg;
        pay_next       = pay_reg;
        keep_next      = keep_reg;
        crc_next       = crc_reg;
        rxc_next       = rxc_reg;
        run_next       = run_reg;
        step_next      = step_reg;
        acc_next       = acc_reg;
        sum_next       = sum_reg;
        w_next         = w_reg;
        j_next         = j_reg;
        e_next         = e_reg;
        sub_next       = sub_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_byte_next  = out_byte_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        done           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    job_next   = job;
                    issue_next = '0;
                    crc_next   = cfg.crc_seed;
                    keep_next  = '0;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // Issue store reads
                if (issue_reg < scan_end)
                begin
                    dv_next    = 1'b1;
                    didx_next  = issue_reg;
                    issue_next = issue_reg + 5'd1;
                end
                // Take the byte read last cycle
                if (dv_reg)
                begin
                    if (didx_reg < HEAD_BYTES)
                    begin
                        hdr_next[didx_reg[2:0]] = mem_q;
                    end
                    else if (didx_reg < SCAN_MIN)
                    begin
                        pay_next[pi] = mem_q;
                        if (!pi[0])
                        begin
                            keep_next[pi[3:1]] = (mem_q != 8'hFF);
                        end
                    end
                    if (didx_reg < job_reg.flen - TAIL_BYTES)
                    begin
                        crc_next = crc_byte(crc_reg, mem_q);
                    end
                    if (didx_reg == job_reg.flen - 5'd2)
                    begin
                        rxc_next[7:0] = mem_q;
                    end
                    if (didx_reg == job_reg.flen - 5'd1)
                    begin
                        rxc_next[15:8] = mem_q;
                    end
                    if (didx_reg == scan_end - 5'd1)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end

            S_CHECK:
            begin
                keep_next = keep_act;
                run_next  = '0;
                step_next = '0;
                acc_next  = '0;
                sum_next  = '0;
                j_next    = '0;
                sub_next  = '0;
                e_next    = first_pick.idx;
                if ((cfg.check_address && addr_rx != cfg.expected_addr)
                    || hdr_reg[4] != cfg.expected_cmd || rxc_reg != crc_reg
                    || job_reg.plen == 5'd0 || job_reg.mode > MODE_WORK
                    || (job_reg.mode == MODE_SCHED && !first_pick.found))
                begin
                    // Single result frame
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = 8'h00;
                        last_next      = 1'b1;
                        if (cfg.check_address && addr_rx != cfg.expected_addr)
                        begin
                            status_next = ST_BAD_ADDR;
                        end
                        else if (hdr_reg[4] != cfg.expected_cmd)
                        begin
                            status_next = ST_BAD_CMD;
                        end
                        else if (rxc_reg != crc_reg)
                        begin
                            status_next = ST_BAD_CRC;
                        end
                        else
                        begin
                            status_next = ST_OK;
                        end
                        done       = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (job_reg.mode == MODE_CNT || job_reg.mode == MODE_VAP
                         || job_reg.mode == MODE_WORK)
                begin
                    state_next = S_RUN;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end

            S_RUN:
            begin
                // One digit pair per cycle
                if (step_reg == ri.len - 3'd1)
                begin
                    w_next[run_reg] = acc_step;
                    sum_next        = sum_reg + acc_step;
                    acc_next        = '0;
                    step_next       = '0;
                    if (run_reg == run_count(job_reg.mode) - 3'd1)
                    begin
                        w_next[4]  = sum_reg + acc_step;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        run_next = run_reg + 3'd1;
                    end
                end
                else
                begin
                    acc_next  = acc_step;
                    step_next = step_reg + 3'd1;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_DATA;
                    j_next         = j_reg + 5'd1;
                    case (job_reg.mode)
                        MODE_RAW:
                        begin
                            out_byte_next = pay_rd;
                            last_next     = (j_reg == job_reg.plen - 5'd1);
                        end
                        MODE_DATE:
                        begin
                            out_byte_next = (j_reg < job_reg.plen) ? bcd2(pay_rd) : 8'h00;
                            last_next     = (j_reg == 5'd6);
                        end
                        MODE_SCHED:
                        begin
                            case (sub_reg)
                                2'd0:    out_byte_next = {6'h00, pay_rd[7:6]};
                                2'd1:    out_byte_next = ({6'h00, pay_rd[5:4]} * 8'd10)
                                                         + {4'h0, pay_rd[3:0]};
                                default: out_byte_next = bcd2(pay_rd);
                            endcase
                            last_next = (sub_reg == 2'd2) && !next_pick.found;
                            if (sub_reg == 2'd2)
                            begin
                                sub_next = '0;
                                e_next   = next_pick.idx;
                            end
                            else
                            begin
                                sub_next = sub_reg + 2'd1;
                            end
                        end
                        default:
                        begin
                            out_byte_next = 8'(wv >> {sel.bsel, 3'b000});
                            last_next     = (j_reg == word_count(job_reg.mode) - 5'd1);
                        end
                    endcase
                    if (last_next)
                    begin
                        done       = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            job_reg       <= '0;
            issue_reg     <= '0;
            dv_reg        <= 1'b0;
            didx_reg      <= '0;
            hdr_reg       <= '{default: '0};
            pay_reg       <= '{default: '0};
            keep_reg      <= '0;
            crc_reg       <= '0;
            rxc_reg       <= '0;
            run_reg       <= '0;
            step_reg      <= '0;
            acc_reg       <= '0;
            sum_reg       <= '0;
            w_reg         <= '{default: '0};
            j_reg         <= '0;
            e_reg         <= '0;
            sub_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            status_reg    <= ST_DATA;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            job_reg       <= job_next;
            issue_reg     <= issue_next;
            dv_reg        <= dv_next;
            didx_reg      <= didx_next;
            hdr_reg       <= hdr_next;
            pay_reg       <= pay_next;
            keep_reg      <= keep_next;
            crc_reg       <= crc_next;
            rxc_reg       <= rxc_next;
            run_reg       <= run_next;
            step_reg      <= step_next;
            acc_reg       <= acc_next;
            sum_reg       <= sum_next;
            w_reg         <= w_next;
            j_reg         <= j_next;
            e_reg         <= e_next;
            sub_reg       <= sub_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            status_reg    <= status_next;
            last_reg      <= last_next;
        end
    end

endmodule

// ===== hdl/meter_reply_frame_decoder.sv =====
// Meter reply frame decoder. Takes one received byte per beat: a 4-byte
// little-endian address, the command byte, payload_length payload bytes
// (clamped to 16) and a little-endian CRC-16 (reflected 0xA001, seeded by
// crc_seed). Bytes are taken one per cycle until the frame's last byte;
// the input then stalls while the back end works on the frame. The back
// end takes the job in the cycle after the last byte, scans the frame
// store once over max(frame length, 21) bytes with one store read port,
// checks address, command and CRC, folds BCD digit pairs one per cycle
// for the counter, volt-amp-power and working-time modes, then gives one
// result per cycle that the output is not stalled. The result register
// lets a finished beat wait at the output; input resumes once the frame's
// last result is loaded.
module meter_reply_frame_decoder #(
    parameter int FRAME_BYTES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic [2:0]  status,
    output logic        last
);
    import mrfd_pkg::*;

    cfg_t cfg;
    wr_t  wr;
    job_t job_in;
    job_t job_head;
    logic push;
    logic pop;
    logic done;
    logic q_empty;
    logic q_full;
    logic back_busy;

    mrfd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .cfg       (cfg),
        .wr        (wr),
        .job       (job_in),
        .push      (push),
        .done      (done)
    );

    mrfd_job_q u_job_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (job_in),
        .pop   (pop),
        .head  (job_head),
        .empty (q_empty),
        .full  (q_full)
    );

    mrfd_back #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .wr        (wr),
        .job       (job_head),
        .q_empty   (q_empty),
        .pop       (pop),
        .done      (done),
        .busy      (back_busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .status    (status),
        .last      (last)
    );

    // Error and no-data results are single zero beats
    a_single_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_DATA |-> out_byte == 8'h00 && last)
        else $error("status beat not a single zero beat");

    // A frame end never finds the job queue full
    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("job queue overflow");

    // Store is never written while the back end reads it
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> !back_busy && q_empty)
        else $error("byte taken while a frame is in progress");

endmodule
